@@ sv/gregorian_to_lunar_date_macros.svh @@
// Assertion helpers, clocked on clock
`ifndef GREGORIAN_TO_LUNAR_DATE_MACROS_SVH
`define GREGORIAN_TO_LUNAR_DATE_MACROS_SVH

// checked outside reset only
`define G2L_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define G2L_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/g2l_pkg.sv @@
package g2l_pkg;

   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int OFF_W   = 18;   // signed day offset from 1900-01-31
   localparam int SPAN_W  = 9;    // up to one lunar year of days
   localparam int ROM_W   = 17;
   localparam int IDX_W   = 8;

   localparam int FIRST_YEAR    = 1900;
   localparam int LAST_YEAR_DEF = 2100;
   localparam int YEAR_COUNT    = 201;
   localparam int MONTH_END     = 13;

   localparam int YEAR_BASE_DAYS = 348;   // twelve short months
   localparam int LONG_MONTH     = 30;
   localparam int SHORT_MONTH    = 29;

   // bits 15..4: months 1..12 long; 3..0: leap month; 16: leap month long
   localparam logic [ROM_W-1:0] YEAR_ROM [YEAR_COUNT] = '{
      17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554, 17'h056a0,
      17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250, 17'h1d255, 17'h0b540,
      17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970, 17'h0a4b0, 17'h0b4b5, 17'h06a50,
      17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570, 17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0,
      17'h0ea50, 17'h06e95, 17'h05ad0, 17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950,
      17'h0d4a0, 17'h1d8a6, 17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2,
      17'h0a950, 17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5b0, 17'h14573,
      17'h052b0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60, 17'h0aae4,
      17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0, 17'h096d0, 17'h04dd5,
      17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558, 17'h0b540, 17'h0b6a0, 17'h195a6,
      17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0, 17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46,
      17'h0ab60, 17'h09570, 17'h04af5, 17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58,
      17'h055c0, 17'h0ab60, 17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50,
      17'h07552, 17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
      17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0, 17'h0a930,
      17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6, 17'h0a4e0, 17'h0d260,
      17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0, 17'h04afb, 17'h04ad0, 17'h0a4d0,
      17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45, 17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0,
      17'h0a577, 17'h0a4b0, 17'h0aa50, 17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63, 17'h09370,
      17'h049f8, 17'h04970, 17'h064b0, 17'h168a6, 17'h0ea50, 17'h06b20, 17'h1a6c4, 17'h0aae0,
      17'h0a2e0, 17'h0d2e3, 17'h0c960, 17'h0d557, 17'h0d4a0, 17'h0da50, 17'h05d55, 17'h056a0,
      17'h0a6d0, 17'h055d4, 17'h052d0, 17'h0a9b8, 17'h0a950, 17'h0b4a0, 17'h0b6a6, 17'h0ad50,
      17'h055a0, 17'h0aba4, 17'h0a5b0, 17'h052b0, 17'h0b273, 17'h06930, 17'h07337, 17'h06aa0,
      17'h0ad50, 17'h14b55, 17'h04b60, 17'h0a570, 17'h054e4, 17'h0d160, 17'h0e968, 17'h0d520,
      17'h0daa0, 17'h16aa6, 17'h056d0, 17'h04ae0, 17'h0a9d4, 17'h0a2d0, 17'h0d150, 17'h0f252,
      17'h0d520
   };

   function automatic logic [ROM_W-1:0] year_entry(input logic [IDX_W-1:0] idx);
      if (idx < IDX_W'(YEAR_COUNT)) begin
         return YEAR_ROM[idx];
      end
      return '0;
   endfunction

   function automatic logic [DAY_W-1:0] leap_len(input logic [ROM_W-1:0] entry);
      if (entry[3:0] == 4'd0) begin
         return '0;
      end
      return entry[16] ? DAY_W'(LONG_MONTH) : DAY_W'(SHORT_MONTH);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [ROM_W-1:0] entry,
                                                  input logic [MONTH_W-1:0] mon);
      logic [4:0] pos;
      pos = 5'd16 - {1'b0, mon};
      return entry[pos] ? DAY_W'(LONG_MONTH) : DAY_W'(SHORT_MONTH);
   endfunction

   function automatic logic [SPAN_W-1:0] year_len(input logic [ROM_W-1:0] entry);
      logic [3:0] cnt;
      cnt = '0;
      for (int b = 4; b < 16; b++) begin
         cnt = cnt + 4'(entry[b]);
      end
      return SPAN_W'(YEAR_BASE_DAYS) + SPAN_W'(cnt) + SPAN_W'(leap_len(entry));
   endfunction

endpackage

@@ sv/g2l_if.sv @@
interface g2l_req_if;
   logic                          valid;
   logic                          ready;
   logic [g2l_pkg::YEAR_W-1:0]    greg_year;
   logic [g2l_pkg::MONTH_W-1:0]   greg_month;
   logic [g2l_pkg::DAY_W-1:0]     greg_day;

   modport source (output valid, greg_year, greg_month, greg_day, input ready);
   modport sink   (input valid, greg_year, greg_month, greg_day, output ready);
endinterface

interface g2l_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          valid_res;
   logic [g2l_pkg::YEAR_W-1:0]    lun_year;
   logic [g2l_pkg::MONTH_W-1:0]   lunar_month;
   logic [g2l_pkg::DAY_W-1:0]     lunar_day;
   logic                          is_leap_month;

   modport source (output valid, valid_res, lun_year, lunar_month, lunar_day,
                   is_leap_month, input ready);
   modport sink   (input valid, valid_res, lun_year, lunar_month, lunar_day,
                   is_leap_month, output ready);
endinterface

@@ sv/g2l_day_num.sv @@
// Civil day count relative to 1900-01-31, two register stages.
module g2l_day_num (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [g2l_pkg::YEAR_W-1:0]          year,
   input  logic [g2l_pkg::MONTH_W-1:0]         month,
   input  logic [g2l_pkg::DAY_W-1:0]           day,
   output logic                                done,
   output logic signed [g2l_pkg::OFF_W-1:0]    offset
);

   localparam int SUM_W      = 20;
   localparam int ERA_DAYS   = 146097;
   localparam int EPOCH_DAYS = 109544;  // 1900-01-31 within its era, plus one
   localparam int ERA4_START = 1600;
   localparam int ERA5_START = 2000;
   localparam logic [SUM_W-1:0] BIAS_ERA4 = SUM_W'(-EPOCH_DAYS);
   localparam logic [SUM_W-1:0] BIAS_ERA5 = SUM_W'(ERA_DAYS - EPOCH_DAYS);

   // days before month k of a March-based year
   function automatic logic [8:0] days_before(input logic [3:0] k);
      case (k)
         4'd0:    return 9'd0;
         4'd1:    return 9'd31;
         4'd2:    return 9'd61;
         4'd3:    return 9'd92;
         4'd4:    return 9'd122;
         4'd5:    return 9'd153;
         4'd6:    return 9'd184;
         4'd7:    return 9'd214;
         4'd8:    return 9'd245;
         4'd9:    return 9'd275;
         4'd10:   return 9'd306;
         4'd11:   return 9'd337;
         4'd12:   return 9'd367;
         default: return 9'd0;
      endcase
   endfunction

   logic [g2l_pkg::YEAR_W-1:0] shift_year;
   logic                       era5;
   logic [g2l_pkg::YEAR_W-1:0] yoe_full;
   logic [8:0]                 yoe;
   logic [3:0]                 mk;
   logic [1:0]                 q100;
   logic [9:0]                 small_in;
   logic [17:0]                prod_in;
   logic [SUM_W-1:0]           sum;

   logic                       s1_ff, s2_ff;
   logic [17:0]                prod_ff;
   logic [9:0]                 small_ff;
   logic                       era5_ff;
   logic signed [g2l_pkg::OFF_W-1:0] off_ff;

   assign shift_year = year - g2l_pkg::YEAR_W'(month <= 4'd2);
   assign era5       = shift_year >= g2l_pkg::YEAR_W'(ERA5_START);
   assign yoe_full   = era5 ? shift_year - g2l_pkg::YEAR_W'(ERA5_START)
                            : shift_year - g2l_pkg::YEAR_W'(ERA4_START);
   assign yoe        = yoe_full[8:0];
   assign mk         = (month > 4'd2) ? month - 4'd3 : month + 4'd9;
   assign q100       = (yoe >= 9'd300) ? 2'd3 :
                       (yoe >= 9'd200) ? 2'd2 :
                       (yoe >= 9'd100) ? 2'd1 : 2'd0;
   assign small_in   = 10'(yoe[8:2]) - 10'(q100) + 10'(days_before(mk)) + 10'(day);
   assign prod_in    = 18'(yoe) * 18'd365;
   assign sum        = SUM_W'(prod_ff) + SUM_W'(small_ff) + (era5_ff ? BIAS_ERA5 : BIAS_ERA4);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= start;
         s2_ff <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff  <= prod_in;
         small_ff <= small_in;
         era5_ff  <= era5;
      end
      if (s1_ff) begin
         off_ff <= $signed(sum[g2l_pkg::OFF_W-1:0]);
      end
   end

   assign done   = s2_ff;
   assign offset = off_ff;

endmodule

@@ sv/gregorian_to_lunar_date.sv @@
// Gregorian to Chinese lunar date. Each request transfer carries a Gregorian
// year, month and day; one response transfer follows with the lunar year,
// month, day and a leap-month flag, or valid_res=0 with all fields zero for
// years outside 1900..LAST_YEAR, dates before 1900-01-31 or dates past the
// last table year. Month and day are not range checked: Feb 31 counts as
// early March. One item is in flight at a time; req ready is high only
// while idle. From request transfer to response valid the steps are the
// civil day count, the lunar years stepped and a closing step, the months
// stepped in the final year and a closing step, and the load of the
// response register. A year outside the range goes straight to the response
// load; a date before 1900-01-31 goes there after the civil day count. The
// load waits while the previous response still waits for rsp ready. The
// walk uses a single offset adder that takes one year-table entry (or one
// month) per cycle.
// A finished result sits in the response register, so a new request can be
// taken while the previous response is still waiting to be transferred.
`include "gregorian_to_lunar_date_macros.svh"

module gregorian_to_lunar_date #(
   parameter int LAST_YEAR = g2l_pkg::LAST_YEAR_DEF
) (
   input  logic         clock,
   input  logic         reset,
   g2l_req_if.sink      req_if,
   g2l_rsp_if.source    rsp_if
);

   localparam int YW  = g2l_pkg::YEAR_W;
   localparam int MW  = g2l_pkg::MONTH_W;
   localparam int DW  = g2l_pkg::DAY_W;
   localparam int OW  = g2l_pkg::OFF_W;
   localparam int SW  = g2l_pkg::SPAN_W;
   localparam logic [YW-1:0] FIRST_Y = YW'(g2l_pkg::FIRST_YEAR);
   localparam logic [YW-1:0] LAST_Y  = YW'(LAST_YEAR);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,   // waiting for a request
      ST_DAYS  = 5'b00010,   // civil day count in flight
      ST_YEAR  = 5'b00100,   // stepping whole lunar years
      ST_MONTH = 5'b01000,   // stepping months of the found year
      ST_OUT   = 5'b10000    // loading the response register
   } state_type;

   typedef struct packed {
      logic          valid_res;
      logic [YW-1:0] lun_year;
      logic [MW-1:0] lunar_month;
      logic [DW-1:0] lunar_day;
      logic          is_leap_month;
   } res_type;

   state_type                state_ff, state_in;
   logic signed [OW-1:0]     off_ff, off_in;      // days left to place
   logic [SW-1:0]            span_ff, span_in;    // last amount taken off
   logic [YW-1:0]            ly_ff, ly_in;
   logic [MW-1:0]            mi_ff, mi_in;
   logic                     in_leap_ff, in_leap_in;
   logic                     ok_ff, ok_in;
   logic [DW-1:0]            day_ff, day_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   res_type                  rsp_res_ff, rsp_res_in;

   // day counter
   logic                     req_xfer;
   logic                     year_ok;
   logic                     dn_done;
   logic signed [OW-1:0]     dn_off;

   // year table read for the current lunar year
   logic [YW-1:0]                  ly_rel;
   logic [g2l_pkg::ROM_W-1:0]      entry;
   logic [SW-1:0]                  ylen;
   logic [MW-1:0]                  leap_mon;
   logic [DW-1:0]                  leap_days;
   logic [DW-1:0]                  mon_days;

   // walk conditions
   logic                     off_pos, off_neg, off_zero;
   logic                     year_walk, mon_walk;
   logic                     at_leap, take_leap;
   logic [SW-1:0]            walk_span;
   logic [YW-1:0]            ly_fix;

   // closing values of the month walk
   logic                     bnd;
   logic                     fin_leap;
   logic [MW-1:0]            fin_mi;
   logic [DW-1:0]            fin_day;

   // shared offset adder
   logic                     alu_sub;
   logic [SW-1:0]            alu_span;
   logic signed [OW-1:0]     alu_opnd;
   logic signed [OW-1:0]     alu_sum;

   assign req_xfer = req_if.valid && req_if.ready;
   assign year_ok  = (req_if.greg_year >= FIRST_Y) && (req_if.greg_year <= LAST_Y);

   g2l_day_num u_day_num (
      .clock  (clock),
      .reset  (reset),
      .start  (req_xfer && year_ok),
      .year   (req_if.greg_year),
      .month  (req_if.greg_month),
      .day    (req_if.greg_day),
      .done   (dn_done),
      .offset (dn_off)
   );

   assign ly_rel    = ly_ff - FIRST_Y;
   assign entry     = g2l_pkg::year_entry(ly_rel[g2l_pkg::IDX_W-1:0]);
   assign ylen      = g2l_pkg::year_len(entry);
   assign leap_mon  = entry[3:0];
   assign leap_days = g2l_pkg::leap_len(entry);
   assign mon_days  = g2l_pkg::month_len(entry, mi_ff);

   assign off_neg   = off_ff[OW-1];
   assign off_zero  = (off_ff == '0);
   assign off_pos   = !off_neg && !off_zero;
   assign year_walk = (ly_ff <= LAST_Y) && off_pos;
   assign mon_walk  = (mi_ff < MW'(g2l_pkg::MONTH_END)) && off_pos;

   // the leap month is walked as a second pass right after its base month
   assign at_leap   = (leap_mon != '0) && ({1'b0, mi_ff} == ({1'b0, leap_mon} + 5'd1));
   assign take_leap = at_leap && !in_leap_ff;
   assign walk_span = take_leap ? SW'(leap_days) : SW'(mon_days);
   assign ly_fix    = off_neg ? ly_ff - YW'(1) : ly_ff;

   // offset exactly on a month boundary: day 1 of the leap pass when one follows
   assign bnd      = off_zero && at_leap;
   assign fin_leap = bnd ? !in_leap_ff : in_leap_ff;
   assign fin_mi   = ((bnd && !in_leap_ff) || off_neg) ? mi_ff - MW'(1) : mi_ff;
   assign fin_day  = off_neg ? alu_sum[DW-1:0] + DW'(1) : off_ff[DW-1:0] + DW'(1);

   // one adder: takes a span off while walking, gives the last one back on overshoot
   always_comb begin
      case (state_ff)
         ST_YEAR: begin
            alu_sub  = year_walk;
            alu_span = year_walk ? ylen : span_ff;
         end
         ST_MONTH: begin
            alu_sub  = mon_walk;
            alu_span = mon_walk ? walk_span : span_ff;
         end
         default: begin
            alu_sub  = 1'b0;
            alu_span = span_ff;
         end
      endcase
   end

   assign alu_opnd = $signed(OW'(alu_span));
   assign alu_sum  = alu_sub ? off_ff - alu_opnd : off_ff + alu_opnd;

   always_comb begin
      state_in     = state_ff;
      off_in       = off_ff;
      span_in      = span_ff;
      ly_in        = ly_ff;
      mi_in        = mi_ff;
      in_leap_in   = in_leap_ff;
      ok_in        = ok_ff;
      day_in       = day_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_res_in   = rsp_res_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               ok_in    = 1'b0;
               state_in = year_ok ? ST_DAYS : ST_OUT;
            end
         end
         ST_DAYS: begin
            if (dn_done) begin
               off_in  = dn_off;
               ly_in   = FIRST_Y;
               span_in = '0;
               // before 1900-01-31 there is no table entry
               state_in = dn_off[OW-1] ? ST_OUT : ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (year_walk) begin
               off_in  = alu_sum;
               span_in = ylen;
               ly_in   = ly_ff + YW'(1);
            end else begin
               if (off_neg) begin
                  off_in = alu_sum;
               end
               ly_in = ly_fix;
               if (ly_fix > LAST_Y) begin
                  state_in = ST_OUT;            // past the table end
               end else begin
                  mi_in      = MW'(1);
                  in_leap_in = 1'b0;
                  span_in    = '0;
                  state_in   = ST_MONTH;
               end
            end
         end
         ST_MONTH: begin
            if (mon_walk) begin
               off_in  = alu_sum;
               span_in = walk_span;
               if (take_leap) begin
                  in_leap_in = 1'b1;
               end else begin
                  mi_in = mi_ff + MW'(1);
                  if (in_leap_ff && at_leap) begin
                     in_leap_in = 1'b0;
                  end
               end
            end else begin
               ok_in      = 1'b1;
               mi_in      = fin_mi;
               in_leap_in = fin_leap;
               day_in     = fin_day;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               if (ok_ff) begin
                  rsp_res_in.valid_res     = 1'b1;
                  rsp_res_in.lun_year      = ly_ff;
                  rsp_res_in.lunar_month   = mi_ff;
                  rsp_res_in.lunar_day     = day_ff;
                  rsp_res_in.is_leap_month = in_leap_ff;
               end else begin
                  rsp_res_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff     <= off_in;
      span_ff    <= span_in;
      ly_ff      <= ly_in;
      mi_ff      <= mi_in;
      in_leap_ff <= in_leap_in;
      ok_ff      <= ok_in;
      day_ff     <= day_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.valid_res     = rsp_res_ff.valid_res;
   assign rsp_if.lun_year      = rsp_res_ff.lun_year;
   assign rsp_if.lunar_month   = rsp_res_ff.lunar_month;
   assign rsp_if.lunar_day     = rsp_res_ff.lunar_day;
   assign rsp_if.is_leap_month = rsp_res_ff.is_leap_month;

   // ---- assertions ----
   `G2L_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid_ff && state_ff == ST_IDLE,
                      "reset did not clear the sequencer")
   `G2L_ASSERT(a_year_bound, state_ff == ST_YEAR |-> ly_ff <= LAST_Y + YW'(1),
               "year walk ran past the table")
   `G2L_ASSERT(a_invalid_zero, rsp_valid_ff && !rsp_res_ff.valid_res |-> rsp_res_ff == '0,
               "invalid response with nonzero fields")
   `G2L_ASSERT(a_valid_range, rsp_valid_ff && rsp_res_ff.valid_res |->
               rsp_res_ff.lunar_month >= MW'(1) && rsp_res_ff.lunar_month <= MW'(12) &&
               rsp_res_ff.lunar_day >= DW'(1) && rsp_res_ff.lunar_day <= DW'(30),
               "lunar month or day out of range")

endmodule
